// ===== rtl/core/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle collision response package
// Shared types, codes, stage map and fixed-point helpers of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

  localparam int WordW      = 32;
  localparam int FracW      = 16;
  localparam int MassW      = 31;
  localparam int OpW        = 3;
  localparam int InDataW    = 352;
  localparam int OutDataW   = 256;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;
  localparam int AddrW      = 4;

  localparam logic [OpW-1:0] OP_PAIR   = 3'd0;
  localparam logic [OpW-1:0] OP_LEFT   = 3'd1;
  localparam logic [OpW-1:0] OP_RIGHT  = 3'd2;
  localparam logic [OpW-1:0] OP_BOTTOM = 3'd3;
  localparam logic [OpW-1:0] OP_TOP    = 3'd4;

  localparam logic [1:0] REG_WALL_LEFT   = 2'd0;
  localparam logic [1:0] REG_WALL_RIGHT  = 2'd1;
  localparam logic [1:0] REG_WALL_BOTTOM = 2'd2;
  localparam logic [1:0] REG_WALL_TOP    = 2'd3;

  localparam logic [31:0] WALL_LEFT_RST   = 32'h0000_0000;
  localparam logic [31:0] WALL_RIGHT_RST  = 32'h0280_0000;
  localparam logic [31:0] WALL_BOTTOM_RST = 32'h0000_0000;
  localparam logic [31:0] WALL_TOP_RST    = 32'h01E0_0000;

  localparam int SqrtSteps = 32;
  localparam int EdivSteps = 17;
  localparam int DivSteps  = 33;

  localparam int ST_MULT_T = 0;
  localparam int ST_ADV    = 1;
  localparam int ST_DIFF   = 2;
  localparam int ST_SQ     = 3;
  localparam int ST_SUM    = 4;
  localparam int ST_WFIN   = 5;
  localparam int ST_SQRT0  = 6;
  localparam int ST_LEN    = ST_SQRT0 + SqrtSteps;
  localparam int ST_EDIV0  = ST_LEN + 1;
  localparam int ST_E      = ST_EDIV0 + EdivSteps;
  localparam int ST_NM     = ST_E + 1;
  localparam int ST_N      = ST_E + 2;
  localparam int ST_EM     = ST_E + 3;
  localparam int ST_R      = ST_E + 4;
  localparam int ST_MAG    = ST_E + 5;
  localparam int ST_DINIT  = ST_E + 6;
  localparam int ST_DIV0   = ST_E + 7;
  localparam int ST_AL     = ST_DIV0 + DivSteps;
  localparam int ST_FM     = ST_AL + 1;
  localparam int ST_FV     = ST_AL + 2;
  localparam int ST_FT     = ST_AL + 3;
  localparam int ST_FP     = ST_AL + 4;
  localparam int ST_SEL    = ST_AL + 5;
  localparam int NumStages = ST_SEL + 1;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] wprod_t;

  typedef enum logic [2:0] {
    KIND_PAIR,
    KIND_LEFT,
    KIND_RIGHT,
    KIND_BOTTOM,
    KIND_TOP,
    KIND_PASS
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    word_t            pax;
    word_t            pay;
    word_t            vax;
    word_t            vay;
    logic [MassW-1:0] ma;
    word_t            pbx;
    word_t            pby;
    word_t            vbx;
    word_t            vby;
    logic [MassW-1:0] mb;
    word_t            t;
  } item_t;

  typedef struct packed {
    word_t left;
    word_t right;
    word_t bottom;
    word_t top;
  } walls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    item_t        it;
    word_t        ax;
    word_t        ay;
    word_t        bx;
    word_t        by;
    logic [31:0]  msum;
    word_t        dx;
    word_t        dy;
    logic         deg;
    word_t        wterm;
    word_t        wpx;
    word_t        wpy;
    word_t        wvx;
    word_t        wvy;
    word_t        wr0;
    word_t        wr1;
    prod_t        p0;
    prod_t        p1;
    prod_t        p2;
    prod_t        p3;
    logic [63:0]  sq;
    logic [63:0]  root;
    logic [31:0]  len;
    logic [31:0]  remx;
    logic [31:0]  remy;
    logic         bitx;
    logic         bity;
    logic [16:0]  qx;
    logic [16:0]  qy;
    logic signed [17:0] ex;
    logic signed [17:0] ey;
    word_t        na;
    word_t        nb;
    word_t        rax;
    word_t        ray;
    word_t        rbx;
    word_t        rby;
    wprod_t       e0;
    wprod_t       e1;
    wprod_t       e2;
    wprod_t       e3;
    logic [65:0]  mga;
    logic [65:0]  mgb;
    logic         nega;
    logic         negb;
    logic         ovfa;
    logic         ovfb;
    logic [31:0]  rema;
    logic [31:0]  remb;
    logic [32:0]  qa;
    logic [32:0]  qb;
    word_t        al;
    word_t        bl;
    word_t        r0;
    word_t        r1;
    word_t        r2;
    word_t        r3;
    word_t        r4;
    word_t        r5;
    word_t        r6;
    word_t        r7;
  } ctx_t;

  function automatic word_t sat48(input logic signed [47:0] x);
    word_t r;
    if (x > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic prod_t mulw(input word_t a, input word_t b);
    return 64'(a) * 64'(b);
  endfunction

  // Product scaled down by the fraction width, truncated toward zero, saturated.
  function automatic word_t qt(input prod_t p);
    prod_t b;
    prod_t s;
    b = p + (p[63] ? 64'sd65535 : 64'sd0);
    s = b >>> FracW;
    return sat48(s[47:0]);
  endfunction

  function automatic logic [31:0] mag32(input word_t x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic word_t lim_word(input logic [32:0] q, input logic ovf, input logic neg);
    logic [32:0] lim;
    logic [32:0] v;
    logic [33:0] s;
    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    v   = (ovf || q > lim) ? lim : q;
    s   = neg ? -{1'b0, v} : {1'b0, v};
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ccr_front.sv =====
// ----------------------------------------------------------------------------
// Circle collision response front end
// Takes input beats, decodes the event kind and hands items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_ax, pos_ay, vel_ax, vel_ay, mass_a, pos_bx, pos_by, vel_bx, vel_by,
  // mass_b_or_radius, event_time, zero fill
  input  wire logic [ccr_pkg::InDataW-1:0] s_axis_tdata,
  // op
  input  wire logic [ccr_pkg::OpW-1:0]     s_axis_tuser,
  input  wire ccr_pkg::q_stat_t       stat_i,
  output logic                        push_o,
  output ccr_pkg::item_t              item_o
);
  import ccr_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  acc;
  kind_e kind;

  always_comb begin
    case (s_axis_tuser)
      OP_PAIR:   kind = KIND_PAIR;
      OP_LEFT:   kind = KIND_LEFT;
      OP_RIGHT:  kind = KIND_RIGHT;
      OP_BOTTOM: kind = KIND_BOTTOM;
      OP_TOP:    kind = KIND_TOP;
      default:   kind = KIND_PASS;
    endcase
  end

  assign s_axis_tready = !vld_q || !stat_i.full;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign push_o        = vld_q && !stat_i.full;
  assign item_o        = item_q;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (push_o) begin
      vld_d = 1'b0;
    end
    if (acc) begin
      vld_d       = 1'b1;
      item_d.kind = kind;
      item_d.pax  = s_axis_tdata[31:0];
      item_d.pay  = s_axis_tdata[63:32];
      item_d.vax  = s_axis_tdata[95:64];
      item_d.vay  = s_axis_tdata[127:96];
      item_d.ma   = s_axis_tdata[158:128];
      item_d.pbx  = s_axis_tdata[190:159];
      item_d.pby  = s_axis_tdata[222:191];
      item_d.vbx  = s_axis_tdata[254:223];
      item_d.vby  = s_axis_tdata[286:255];
      item_d.mb   = s_axis_tdata[317:287];
      item_d.t    = s_axis_tdata[349:318];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ccr_queue.sv =====
// ----------------------------------------------------------------------------
// Circle collision response item queue
// Short first-in first-out buffer between the front end and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ccr_pkg::item_t  item_i,
  input  wire logic            pop_i,
  output ccr_pkg::item_t       item_o,
  output ccr_pkg::q_stat_t     stat_o
);
  import ccr_pkg::*;

  item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ccr_back.sv =====
// ----------------------------------------------------------------------------
// Circle collision response datapath
// Stall-together pipeline with pipelined square root and dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ccr_pkg::walls_t walls_i,
  input  wire ccr_pkg::item_t  item_i,
  input  wire ccr_pkg::q_stat_t stat_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // new_pos_ax, new_pos_ay, new_vel_ax, new_vel_ay,
  // new_pos_bx, new_pos_by, new_vel_bx, new_vel_by
  output logic [ccr_pkg::OutDataW-1:0] m_axis_tdata,
  // degenerate
  output logic                 m_axis_tuser
);
  import ccr_pkg::*;

  function automatic ctx_t stage_fn(input int s, input ctx_t ci, input walls_t w);
    ctx_t              c;
    logic [63:0]       one;
    logic [32:0]       tx, ty, ta, tb;
    logic [31:0]       mx, my;
    word_t             rad, dm, dn;
    logic signed [33:0] m2a, m2b;
    logic              xk, yk;
    c   = ci;
    rad = $signed({1'b0, c.it.mb});
    xk  = (c.it.kind == KIND_LEFT) || (c.it.kind == KIND_RIGHT);
    yk  = (c.it.kind == KIND_BOTTOM) || (c.it.kind == KIND_TOP);
    if (s == ST_MULT_T) begin
      c.p0 = mulw(c.it.vax, c.it.t);
      c.p1 = mulw(c.it.vay, c.it.t);
      c.p2 = mulw(c.it.vbx, c.it.t);
      c.p3 = mulw(c.it.vby, c.it.t);
    end else if (s == ST_ADV) begin
      c.ax   = sat48(48'(c.it.pax) + 48'(qt(c.p0)));
      c.ay   = sat48(48'(c.it.pay) + 48'(qt(c.p1)));
      c.bx   = sat48(48'(c.it.pbx) + 48'(qt(c.p2)));
      c.by   = sat48(48'(c.it.pby) + 48'(qt(c.p3)));
      c.msum = 32'(c.it.ma) + 32'(c.it.mb);
    end else if (s == ST_DIFF) begin
      c.dx = sat48(48'(c.ax) - 48'(c.bx));
      c.dy = sat48(48'(c.ay) - 48'(c.by));
      case (c.it.kind)
        KIND_LEFT:   c.wterm = sat48(48'(w.left) + 48'(rad));
        KIND_RIGHT:  c.wterm = sat48(48'(w.right) - 48'(rad));
        KIND_BOTTOM: c.wterm = sat48(48'(w.bottom) + 48'(rad));
        KIND_TOP:    c.wterm = sat48(48'(w.top) - 48'(rad));
        default:     c.wterm = '0;
      endcase
      c.wvx = xk ? sat48(-48'(c.it.vax)) : c.it.vax;
      c.wvy = yk ? sat48(-48'(c.it.vay)) : c.it.vay;
    end else if (s == ST_SQ) begin
      c.wpx = xk ? sat48(48'(c.wterm) + 48'(c.wterm) - 48'(c.ax)) : c.ax;
      c.wpy = yk ? sat48(48'(c.wterm) + 48'(c.wterm) - 48'(c.ay)) : c.ay;
      c.deg = (c.it.kind == KIND_PAIR) &&
              (((c.dx == '0) && (c.dy == '0)) || (c.msum == '0));
      c.p0  = mulw(c.dx, c.dx);
      c.p1  = mulw(c.dy, c.dy);
    end else if (s == ST_SUM) begin
      c.sq   = c.p0 + c.p1;
      c.root = '0;
      c.p2   = mulw(c.wvx, c.it.t);
      c.p3   = mulw(c.wvy, c.it.t);
    end else if (s == ST_WFIN) begin
      c.wr0 = sat48(48'(c.wpx) - 48'(qt(c.p2)));
      c.wr1 = sat48(48'(c.wpy) - 48'(qt(c.p3)));
    end else if (s >= ST_SQRT0 && s < ST_LEN) begin
      one = 64'd1 << (62 - 2 * (s - ST_SQRT0));
      if (c.sq >= c.root + one) begin
        c.sq   = c.sq - (c.root + one);
        c.root = (c.root >> 1) + one;
      end else begin
        c.root = c.root >> 1;
      end
    end else if (s == ST_LEN) begin
      mx     = mag32(c.dx);
      my     = mag32(c.dy);
      c.len  = (c.root[31:0] == '0) ? 32'd1 : c.root[31:0];
      c.remx = {1'b0, mx[31:1]};
      c.remy = {1'b0, my[31:1]};
      c.bitx = mx[0];
      c.bity = my[0];
      c.qx   = '0;
      c.qy   = '0;
    end else if (s >= ST_EDIV0 && s < ST_E) begin
      tx = {c.remx, c.bitx};
      ty = {c.remy, c.bity};
      c.bitx = 1'b0;
      c.bity = 1'b0;
      if (tx >= {1'b0, c.len}) begin
        tx     = tx - {1'b0, c.len};
        c.qx   = {c.qx[15:0], 1'b1};
      end else begin
        c.qx   = {c.qx[15:0], 1'b0};
      end
      if (ty >= {1'b0, c.len}) begin
        ty     = ty - {1'b0, c.len};
        c.qy   = {c.qy[15:0], 1'b1};
      end else begin
        c.qy   = {c.qy[15:0], 1'b0};
      end
      c.remx = tx[31:0];
      c.remy = ty[31:0];
    end else if (s == ST_E) begin
      c.ex = c.dx[31] ? -$signed({1'b0, c.qx}) : $signed({1'b0, c.qx});
      c.ey = c.dy[31] ? -$signed({1'b0, c.qy}) : $signed({1'b0, c.qy});
    end else if (s == ST_NM) begin
      c.p0 = mulw(c.it.vax, word_t'(c.ex));
      c.p1 = mulw(c.it.vay, word_t'(c.ey));
      c.p2 = mulw(c.it.vbx, word_t'(c.ex));
      c.p3 = mulw(c.it.vby, word_t'(c.ey));
    end else if (s == ST_N) begin
      c.na = sat48(48'(qt(c.p0)) + 48'(qt(c.p1)));
      c.nb = sat48(48'(qt(c.p2)) + 48'(qt(c.p3)));
    end else if (s == ST_EM) begin
      dm   = $signed({1'b0, c.it.ma}) - $signed({1'b0, c.it.mb});
      dn   = $signed({1'b0, c.it.mb}) - $signed({1'b0, c.it.ma});
      m2a  = $signed({2'b00, c.it.ma, 1'b0});
      m2b  = $signed({2'b00, c.it.mb, 1'b0});
      c.p0 = mulw(c.na, word_t'(c.ex));
      c.p1 = mulw(c.na, word_t'(c.ey));
      c.p2 = mulw(c.nb, word_t'(c.ex));
      c.p3 = mulw(c.nb, word_t'(c.ey));
      c.e0 = 66'(c.na) * 66'(dm);
      c.e1 = 66'(c.nb) * 66'(m2b);
      c.e2 = 66'(c.nb) * 66'(dn);
      c.e3 = 66'(c.na) * 66'(m2a);
    end else if (s == ST_R) begin
      c.rax = sat48(48'(c.it.vax) - 48'(qt(c.p0)));
      c.ray = sat48(48'(c.it.vay) - 48'(qt(c.p1)));
      c.rbx = sat48(48'(c.it.vbx) - 48'(qt(c.p2)));
      c.rby = sat48(48'(c.it.vby) - 48'(qt(c.p3)));
      c.e0  = c.e0 + c.e1;
      c.e2  = c.e2 + c.e3;
    end else if (s == ST_MAG) begin
      c.nega = c.e0[65];
      c.negb = c.e2[65];
      c.mga  = c.e0[65] ? 66'(-c.e0) : 66'(c.e0);
      c.mgb  = c.e2[65] ? 66'(-c.e2) : 66'(c.e2);
    end else if (s == ST_DINIT) begin
      c.ovfa = c.mga[65:33] >= {1'b0, c.msum};
      c.ovfb = c.mgb[65:33] >= {1'b0, c.msum};
      c.rema = c.mga[64:33];
      c.remb = c.mgb[64:33];
      c.qa   = '0;
      c.qb   = '0;
    end else if (s >= ST_DIV0 && s < ST_AL) begin
      ta    = {c.rema, c.mga[32]};
      tb    = {c.remb, c.mgb[32]};
      c.mga = c.mga << 1;
      c.mgb = c.mgb << 1;
      if (ta >= {1'b0, c.msum}) begin
        ta   = ta - {1'b0, c.msum};
        c.qa = {c.qa[31:0], 1'b1};
      end else begin
        c.qa = {c.qa[31:0], 1'b0};
      end
      if (tb >= {1'b0, c.msum}) begin
        tb   = tb - {1'b0, c.msum};
        c.qb = {c.qb[31:0], 1'b1};
      end else begin
        c.qb = {c.qb[31:0], 1'b0};
      end
      c.rema = ta[31:0];
      c.remb = tb[31:0];
    end else if (s == ST_AL) begin
      c.al = lim_word(c.qa, c.ovfa, c.nega);
      c.bl = lim_word(c.qb, c.ovfb, c.negb);
    end else if (s == ST_FM) begin
      c.p0 = mulw(c.al, word_t'(c.ex));
      c.p1 = mulw(c.al, word_t'(c.ey));
      c.p2 = mulw(c.bl, word_t'(c.ex));
      c.p3 = mulw(c.bl, word_t'(c.ey));
    end else if (s == ST_FV) begin
      c.r2 = sat48(48'(c.rax) + 48'(qt(c.p0)));
      c.r3 = sat48(48'(c.ray) + 48'(qt(c.p1)));
      c.r6 = sat48(48'(c.rbx) + 48'(qt(c.p2)));
      c.r7 = sat48(48'(c.rby) + 48'(qt(c.p3)));
    end else if (s == ST_FT) begin
      c.p0 = mulw(c.r2, c.it.t);
      c.p1 = mulw(c.r3, c.it.t);
      c.p2 = mulw(c.r6, c.it.t);
      c.p3 = mulw(c.r7, c.it.t);
    end else if (s == ST_FP) begin
      c.r0 = sat48(48'(c.ax) - 48'(qt(c.p0)));
      c.r1 = sat48(48'(c.ay) - 48'(qt(c.p1)));
      c.r4 = sat48(48'(c.bx) - 48'(qt(c.p2)));
      c.r5 = sat48(48'(c.by) - 48'(qt(c.p3)));
    end else if (s == ST_SEL) begin
      if (c.it.kind != KIND_PAIR || c.deg) begin
        c.r0 = c.it.pax;
        c.r1 = c.it.pay;
        c.r2 = c.it.vax;
        c.r3 = c.it.vay;
        c.r4 = c.it.pbx;
        c.r5 = c.it.pby;
        c.r6 = c.it.vbx;
        c.r7 = c.it.vby;
      end
      if (xk || yk) begin
        c.r0 = c.wr0;
        c.r1 = c.wr1;
        c.r2 = c.wvx;
        c.r3 = c.wvy;
      end
    end
    return c;
  endfunction

  ctx_t ctx_q [NumStages];
  ctx_t ctx_d [NumStages];
  logic [NumStages-1:0] vld_q, vld_d;
  logic en;
  ctx_t in_ctx;

  assign en    = !vld_q[NumStages-1] || m_axis_tready;
  assign pop_o = en && !stat_i.empty;

  always_comb begin
    in_ctx    = '0;
    in_ctx.it = item_i;
    ctx_d[0]  = stage_fn(0, in_ctx, walls_i);
    for (int s = 1; s < NumStages; s++) begin
      ctx_d[s] = stage_fn(s, ctx_q[s-1], walls_i);
    end
    vld_d = {vld_q[NumStages-2:0], !stat_i.empty};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NumStages; s++) begin
        ctx_q[s] <= ctx_d[s];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {ctx_q[NumStages-1].r7, ctx_q[NumStages-1].r6,
                          ctx_q[NumStages-1].r5, ctx_q[NumStages-1].r4,
                          ctx_q[NumStages-1].r3, ctx_q[NumStages-1].r2,
                          ctx_q[NumStages-1].r1, ctx_q[NumStages-1].r0};
  assign m_axis_tuser  = ctx_q[NumStages-1].deg;

endmodule

`default_nettype wire

// ===== rtl/core/circle_collision_response.sv =====
// Path of an input beat: input register, queue, 102 datapath stages
// ending in the output register.
// Throughput: one beat per cycle unless m_axis_tready stalls; the square
// root and both dividers are fully pipelined, one result bit per stage.
// Reset: walls return to their reset values, queue and pipeline empty.
// ----------------------------------------------------------------------------
// Circle collision response
// Resolves circle pair and wall collision events in signed Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_collision_response (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [ccr_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_ax, pos_ay, vel_ax, vel_ay, mass_a, pos_bx, pos_by, vel_bx, vel_by,
  // mass_b_or_radius, event_time, zero fill
  input  wire logic [351:0] s_axis_tdata,
  // op
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // new_pos_ax, new_pos_ay, new_vel_ax, new_vel_ay,
  // new_pos_bx, new_pos_by, new_vel_bx, new_vel_by
  output logic [255:0]     m_axis_tdata,
  // degenerate
  output logic             m_axis_tuser
);
  import ccr_pkg::*;

  walls_t  walls_q, walls_d;
  logic    cfg_wr;
  logic    push, pop;
  item_t   front_item, head_item;
  q_stat_t q_stat;
  logic [7:0] inflight_q, inflight_d;
  logic    in_acc, out_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    walls_d = walls_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_WALL_LEFT:   walls_d.left   = pwdata;
        REG_WALL_RIGHT:  walls_d.right  = pwdata;
        REG_WALL_BOTTOM: walls_d.bottom = pwdata;
        REG_WALL_TOP:    walls_d.top    = pwdata;
        default:         walls_d        = walls_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WALL_LEFT:   prdata = walls_q.left;
      REG_WALL_RIGHT:  prdata = walls_q.right;
      REG_WALL_BOTTOM: prdata = walls_q.bottom;
      REG_WALL_TOP:    prdata = walls_q.top;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walls_q.left   <= WALL_LEFT_RST;
      walls_q.right  <= WALL_RIGHT_RST;
      walls_q.bottom <= WALL_BOTTOM_RST;
      walls_q.top    <= WALL_TOP_RST;
    end else begin
      walls_q <= walls_d;
    end
  end

  ccr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .stat_i       (q_stat),
    .push_o       (push),
    .item_o       (front_item)
  );

  ccr_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(front_item),
    .pop_i (pop),
    .item_o(head_item),
    .stat_o(q_stat)
  );

  ccr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .walls_i      (walls_q),
    .item_i       (head_item),
    .stat_i       (q_stat),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign inflight_d = inflight_q + 8'(in_acc) - 8'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("Queue written while full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> inflight_q != 8'd0)
    else $error("Output beat without an item in flight.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> inflight_q != 8'd0)
    else $error("Accepted beat not counted in flight.");

endmodule

`default_nettype wire

// ===== test/tb_circle_collision_response.sv =====
// ----------------------------------------------------------------------------
// Circle collision response testbench
// Sends pair and wall collision events over the input stream and checks each
// output beat field by field against a fixed-point predictor of the block.
// The wall registers are set over APB between phases, extremes included, and
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circle_collision_response;
  import ccr_pkg::*;

  typedef logic signed [127:0] big_t;

  typedef struct {
    logic [2:0]  op;
    word_t       pax, pay, vax, vay;
    logic [30:0] ma;
    word_t       pbx, pby, vbx, vby;
    logic [30:0] mb;
    word_t       t;
  } event_t;

  typedef struct {
    logic [255:0] data;
    logic         deg;
  } response_t;

  localparam int LimitCycles = 600000;

  logic         clk_i;
  logic         rst_ni;
  logic         psel, penable, pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [255:0] m_axis_tdata;
  logic         m_axis_tuser;

  response_t    pending_responses[$];
  word_t        walls[4];
  int           mismatches;
  int           cycles;
  bit           no_idle;
  int           ready_hold;
  string        field_names[8] = '{"new_pos_ax", "new_pos_ay", "new_vel_ax", "new_vel_ay",
                                   "new_pos_bx", "new_pos_by", "new_vel_bx", "new_vel_by"};

  circle_collision_response dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic big_t clamp(big_t x);
    if (x > 128'sh7FFF_FFFF) begin
      return 128'sh7FFF_FFFF;
    end else if (x < -128'sh8000_0000) begin
      return -128'sh8000_0000;
    end
    return x;
  endfunction

  function automatic big_t fx_mul(big_t a, big_t b);
    big_t p;
    p = a * b;
    return clamp(p / 128'sd65536);
  endfunction

  function automatic big_t root_floor(big_t x);
    logic [63:0] r;
    logic [63:0] c;
    big_t        cc;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      cc = big_t'(c) * big_t'(c);
      if (cc <= x) begin
        r = c;
      end
    end
    return big_t'(r);
  endfunction

  function automatic response_t resolve_event(event_t e);
    response_t res;
    big_t      r[8];
    big_t      ax, ay, bx, by, dx, dy, ma, mb, msum, len, ex, ey;
    big_t      na, nb, rax, ray, rbx, rby, al, bl, px, py, nvx, nvy, t;
    res.deg = 1'b0;
    r[0] = e.pax; r[1] = e.pay; r[2] = e.vax; r[3] = e.vay;
    r[4] = e.pbx; r[5] = e.pby; r[6] = e.vbx; r[7] = e.vby;
    t  = e.t;
    ma = big_t'(e.ma);
    mb = big_t'(e.mb);
    if (e.op == OP_PAIR) begin
      ax   = clamp(r[0] + fx_mul(r[2], t));
      ay   = clamp(r[1] + fx_mul(r[3], t));
      bx   = clamp(r[4] + fx_mul(r[6], t));
      by   = clamp(r[5] + fx_mul(r[7], t));
      dx   = clamp(ax - bx);
      dy   = clamp(ay - by);
      msum = ma + mb;
      if ((dx == 0 && dy == 0) || msum == 0) begin
        res.deg = 1'b1;
      end else begin
        len = root_floor(dx * dx + dy * dy);
        ex  = clamp((dx * 128'sd65536) / len);
        ey  = clamp((dy * 128'sd65536) / len);
        na  = clamp(fx_mul(r[2], ex) + fx_mul(r[3], ey));
        nb  = clamp(fx_mul(r[6], ex) + fx_mul(r[7], ey));
        rax = clamp(r[2] - fx_mul(na, ex));
        ray = clamp(r[3] - fx_mul(na, ey));
        rbx = clamp(r[6] - fx_mul(nb, ex));
        rby = clamp(r[7] - fx_mul(nb, ey));
        al  = clamp((na * (ma - mb) + 2 * mb * nb) / msum);
        bl  = clamp((nb * (mb - ma) + 2 * ma * na) / msum);
        r[2] = clamp(rax + fx_mul(al, ex));
        r[3] = clamp(ray + fx_mul(al, ey));
        r[6] = clamp(rbx + fx_mul(bl, ex));
        r[7] = clamp(rby + fx_mul(bl, ey));
        r[0] = clamp(ax - fx_mul(r[2], t));
        r[1] = clamp(ay - fx_mul(r[3], t));
        r[4] = clamp(bx - fx_mul(r[6], t));
        r[5] = clamp(by - fx_mul(r[7], t));
      end
    end else if (e.op <= OP_TOP) begin
      px  = clamp(r[0] + fx_mul(r[2], t));
      py  = clamp(r[1] + fx_mul(r[3], t));
      nvx = r[2];
      nvy = r[3];
      case (e.op)
        OP_LEFT: begin
          px  = clamp(2 * clamp(big_t'(walls[REG_WALL_LEFT]) + mb) - px);
          nvx = clamp(-r[2]);
        end
        OP_RIGHT: begin
          px  = clamp(2 * clamp(big_t'(walls[REG_WALL_RIGHT]) - mb) - px);
          nvx = clamp(-r[2]);
        end
        OP_BOTTOM: begin
          py  = clamp(2 * clamp(big_t'(walls[REG_WALL_BOTTOM]) + mb) - py);
          nvy = clamp(-r[3]);
        end
        default: begin
          py  = clamp(2 * clamp(big_t'(walls[REG_WALL_TOP]) - mb) - py);
          nvy = clamp(-r[3]);
        end
      endcase
      r[2] = nvx;
      r[3] = nvy;
      r[0] = clamp(px - fx_mul(nvx, t));
      r[1] = clamp(py - fx_mul(nvy, t));
    end
    for (int k = 0; k < 8; k++) begin
      res.data[32*k +: 32] = r[k][31:0];
    end
    return res;
  endfunction

  function automatic word_t rand_word(int span);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2: return $urandom;
      default: return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return $urandom;
      default: return 31'($urandom_range(0, 32'h00FF_FFFF));
    endcase
  endfunction

  function automatic int rand_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic send_event(event_t e);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= e.op;
    s_axis_tdata  <= {2'b00, e.t, e.mb, e.vby, e.vbx, e.pby, e.pbx, e.ma,
                      e.vay, e.vax, e.pay, e.pax};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    pending_responses.push_back(resolve_event(e));
    gap = rand_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_responses.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (110) @(posedge clk_i);
  endtask

  task automatic write_wall(logic [1:0] idx, word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    walls[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic event_t rand_event(logic [2:0] op);
    event_t e;
    e.op  = op;
    e.pax = rand_word(32'h01FF_FFFF);
    e.pay = rand_word(32'h01FF_FFFF);
    e.vax = rand_word(32'h00FF_FFFF);
    e.vay = rand_word(32'h00FF_FFFF);
    e.ma  = rand_mass();
    e.pbx = ($urandom_range(0, 3) == 0) ? e.pax + word_t'($urandom_range(0, 8)) - 4
                                        : rand_word(32'h01FF_FFFF);
    e.pby = ($urandom_range(0, 3) == 0) ? e.pay : rand_word(32'h01FF_FFFF);
    e.vbx = rand_word(32'h00FF_FFFF);
    e.vby = rand_word(32'h00FF_FFFF);
    e.mb  = rand_mass();
    e.t   = ($urandom_range(0, 4) == 0) ? 32'sd0 : rand_word(32'h0002_0000);
    return e;
  endfunction

  task automatic test_directed();
    event_t e;
    e = rand_event(OP_PAIR);
    e.pax = 32'sh0001_0000; e.pay = 0; e.vax = 32'sh0001_0000; e.vay = 0;
    e.pbx = 0; e.pby = 0; e.vbx = 0; e.vby = 0;
    e.ma = 31'h1_0000; e.mb = 31'h1_0000; e.t = 0;
    send_event(e);
    e.pbx = e.pax;
    send_event(e);
    e.pbx = 0; e.ma = 0; e.mb = 0;
    send_event(e);
    e.op = OP_PAIR;
    e.pax = 32'sh7FFF_FFFF; e.pay = 32'sh8000_0000; e.vax = 32'sh7FFF_FFFF;
    e.vay = 32'sh8000_0000; e.ma = 31'h7FFF_FFFF; e.pbx = 32'sh8000_0000;
    e.pby = 32'sh7FFF_FFFF; e.vbx = 32'sh8000_0000; e.vby = 32'sh7FFF_FFFF;
    e.mb = 31'h7FFF_FFFF; e.t = 32'sh7FFF_FFFF;
    send_event(e);
    e.t = 32'sh8000_0000;
    send_event(e);
    for (int op = 1; op <= 7; op++) begin
      e = rand_event(3'(op));
      send_event(e);
      e.vax = 32'sh8000_0000; e.vay = 32'sh8000_0000; e.mb = 31'h7FFF_FFFF;
      e.pax = 32'sh7FFF_FFFF; e.pay = 32'sh7FFF_FFFF;
      send_event(e);
    end
    drain();
  endtask

  task automatic test_wall_settings();
    word_t settings[4][4];
    settings[0] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    settings[1] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    settings[2] = '{-32'sh0064_0000, 32'sh0064_0000, 32'sh0010_0000, 32'sh0400_0000};
    settings[3] = '{WALL_LEFT_RST, WALL_RIGHT_RST, WALL_BOTTOM_RST, WALL_TOP_RST};
    for (int s = 0; s < 4; s++) begin
      write_wall(REG_WALL_LEFT, settings[s][0]);
      write_wall(REG_WALL_RIGHT, settings[s][1]);
      write_wall(REG_WALL_BOTTOM, settings[s][2]);
      write_wall(REG_WALL_TOP, settings[s][3]);
      for (int i = 0; i < 24; i++) begin
        send_event(rand_event(3'($urandom_range(1, 4))));
      end
      drain();
    end
  endtask

  task automatic test_random();
    int r;
    logic [2:0] op;
    for (int i = 0; i < 900; i++) begin
      no_idle = (i >= 300 && i < 400);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        op = OP_PAIR;
      end else if (r < 94) begin
        op = 3'($urandom_range(1, 4));
      end else begin
        op = 3'($urandom_range(5, 7));
      end
      send_event(rand_event(op));
    end
    no_idle = 1'b0;
    drain();
  endtask

  always @(posedge clk_i) begin
    int pick;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        m_axis_tready <= 1'b1;
        ready_hold    <= $urandom_range(0, 3);
      end else if (pick < 92) begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_responses.size() == 0) begin
        report("unexpected beat", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_responses.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (m_axis_tdata[32*k +: 32] !== want.data[32*k +: 32]) begin
            report(field_names[k], m_axis_tdata[32*k +: 32], want.data[32*k +: 32]);
          end
        end
        if (m_axis_tuser !== want.deg) begin
          report("degenerate", 32'(m_axis_tuser), 32'(want.deg));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("tb_circle_collision_response: FAIL");
      $finish;
    end
  end

  initial begin
    cycles        = 0;
    mismatches    = 0;
    no_idle       = 1'b0;
    ready_hold    = 0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    walls         = '{WALL_LEFT_RST, WALL_RIGHT_RST, WALL_BOTTOM_RST, WALL_TOP_RST};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_wall_settings();
    test_random();
    if (pending_responses.size() != 0) begin
      report("responses left over", pending_responses.size(), 0);
    end
    if (mismatches == 0) begin
      $display("tb_circle_collision_response: PASS");
    end else begin
      $display("tb_circle_collision_response: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
